FILE: src/slr_pkg.sv
// Shared types, widths and codes for the packet slot ring allocator.
// No dependencies.
package slr_pkg;

  localparam int SLOTS    = 16;
  localparam int CLIENTS  = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CLIENT_W = $clog2(CLIENTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int HOLD_W   = 5;
  localparam int TICKET_W = 16;
  localparam int HOLD_MAX = 31;

  localparam logic [1:0] MODE_REQ = 2'd0;
  localparam logic [1:0] MODE_REL = 2'd1;
  localparam logic [1:0] MODE_COL = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FREE    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  function automatic logic [CNT_W-1:0] clamp_slots(input logic [4:0] v);
    logic [CNT_W-1:0] r;
    if (v < 5'd2) r = CNT_W'(2);
    else if (32'(v) > SLOTS) r = CNT_W'(SLOTS);
    else r = CNT_W'(v);
    return r;
  endfunction

endpackage

FILE: src/packet_slot_ring_allocator.sv
// Top level: slot ring allocator with link and owner RAMs and a sequencer.
// Depends on slr_pkg and slr_ram.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-----------------------
//  command   | mode client hold_limit slot_in max_list      | start && !busy
//  result    | status slot_out ticket last                  | out_valid, one cycle
//  config    | slots_in_use                                 | slots_in_use_we
//
// Request: a grant passes through S_REQ, a refusal is answered from idle. Release: a free
// slot is answered from idle, the head from S_REL1, others through S_REL1 to S_REL4, set by
// the chain of dependent link RAM reads and writes. Collect: one result beat per listed slot,
// one next-link RAM read per slot. Empty collect and unknown mode are answered from idle.
// Reset and each config write run a clearing pass over every slot that rebuilds
// the ring; busy stays high meanwhile. Results cannot be stalled.
module packet_slot_ring_allocator import slr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [CLIENT_W-1:0] client,
  input  logic [4:0]          hold_limit,
  input  logic [SLOT_W-1:0]   slot_in,
  input  logic [4:0]          max_list,
  input  logic                slots_in_use_we,
  input  logic [4:0]          slots_in_use,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [TICKET_W-1:0] ticket,
  output logic                last
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_REQ, S_REL1, S_REL2, S_REL3, S_REL4, S_COL
  } state_t;

  state_t state;
  logic [CNT_W-1:0]    ring_size;
  logic [SLOT_W-1:0]   clr_idx;
  logic [SLOT_W-1:0]   head_ptr, free_ptr, rel_slot, cur;
  logic [CNT_W-1:0]    iters, count;
  logic [TICKET_W-1:0] ticket_counter;
  logic                slot_busy [SLOTS];
  logic [HOLD_W-1:0]   hold_cnt [CLIENTS];

  // RAM ports
  logic                next_we, prev_we, own_we;
  logic [SLOT_W-1:0]   next_waddr, prev_waddr;
  logic [SLOT_W-1:0]   next_wdata, prev_wdata;
  logic [SLOT_W-1:0]   next_raddr, prev_raddr;
  logic [SLOT_W-1:0]   next_q, prev_q;
  logic [CLIENT_W-1:0] owner_q;

  slr_ram #(.W(SLOT_W), .D(SLOTS)) u_next (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_q)
  );
  slr_ram #(.W(SLOT_W), .D(SLOTS)) u_prev (
    .clk, .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_q)
  );
  slr_ram #(.W(CLIENT_W), .D(SLOTS)) u_owner (
    .clk, .we(own_we), .waddr(free_ptr), .wdata(client),
    .raddr(slot_in), .rdata(owner_q)
  );

  logic                acc;
  logic [CLIENT_W-1:0] hidx;
  logic [HOLD_W-1:0]   hold_rd;
  logic                client_ok, grant_ok, rel_ok, col_empty, col_stop;
  logic [CNT_W-1:0]    clr_nx, count_inc;
  logic [SLOT_W-1:0]   clr_next, clr_prev;

  function automatic logic client_ok_owner(input logic [CLIENT_W-1:0] o);
    return (32'(o) < CLIENTS);
  endfunction

  assign busy      = (state != S_IDLE);
  assign acc       = start && (state == S_IDLE);
  assign hidx      = (state == S_IDLE) ? client : owner_q;
  assign hold_rd   = hold_cnt[hidx];
  assign client_ok = (32'(client) < CLIENTS);
  assign grant_ok  = client_ok && !slot_busy[free_ptr] && (hold_rd < hold_limit);
  assign rel_ok    = ({1'b0, slot_in} < ring_size) && slot_busy[slot_in];
  assign col_empty = !slot_busy[head_ptr] || (max_list == 5'd0);
  assign count_inc = count + CNT_W'(1);
  assign col_stop  = !slot_busy[next_q] || (count_inc >= iters);

  // ring rebuild values for the clearing pass
  assign clr_nx   = CNT_W'(clr_idx) + CNT_W'(1);
  assign clr_next = (clr_nx < ring_size) ? SLOT_W'(clr_nx) : '0;
  assign clr_prev = (clr_idx == '0) ? SLOT_W'(ring_size - CNT_W'(1))
                                    : clr_idx - SLOT_W'(1);

  always_comb begin
    next_raddr = slot_in;
    if (state == S_COL) next_raddr = next_q;
    else if (mode == MODE_REQ) next_raddr = free_ptr;
    else if (mode == MODE_COL) next_raddr = head_ptr;
    prev_raddr = (state == S_REL2) ? free_ptr : slot_in;
    own_we = acc && (mode == MODE_REQ) && grant_ok;

    next_we = 1'b0; next_waddr = clr_idx; next_wdata = clr_next;
    prev_we = 1'b0; prev_waddr = clr_idx; prev_wdata = clr_prev;
    unique case (state)
      S_CLR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_REL1: begin
        // unlink from the busy run unless it is the head
        next_we = (rel_slot != head_ptr); next_waddr = prev_q; next_wdata = next_q;
        prev_we = (rel_slot != head_ptr); prev_waddr = next_q; prev_wdata = prev_q;
      end
      S_REL3: begin
        next_we = 1'b1; next_waddr = prev_q;   next_wdata = rel_slot;
        prev_we = 1'b1; prev_waddr = rel_slot; prev_wdata = prev_q;
      end
      S_REL4: begin
        next_we = 1'b1; next_waddr = rel_slot; next_wdata = free_ptr;
        prev_we = 1'b1; prev_waddr = free_ptr; prev_wdata = rel_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (rst) begin
      state          <= S_CLR;
      clr_idx        <= '0;
      ring_size      <= clamp_slots(5'd16);
      head_ptr       <= '0;
      free_ptr       <= '0;
      ticket_counter <= '0;
      for (int i = 0; i < SLOTS; i++) slot_busy[i] <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) hold_cnt[i] <= '0;
    end else if (slots_in_use_we) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      ring_size <= clamp_slots(slots_in_use);
      head_ptr  <= '0;
      free_ptr  <= '0;
      for (int i = 0; i < SLOTS; i++) slot_busy[i] <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) hold_cnt[i] <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + SLOT_W'(1);
          if (32'(clr_idx) == SLOTS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            status   <= ST_DONE;
            slot_out <= '0;
            ticket   <= '0;
            last     <= 1'b1;
            rel_slot <= slot_in;
            unique case (mode)
              MODE_REQ: begin
                if (grant_ok) begin
                  slot_busy[free_ptr] <= 1'b1;
                  if (32'(hold_rd) < HOLD_MAX) hold_cnt[hidx] <= hold_rd + HOLD_W'(1);
                  state <= S_REQ;
                end else begin
                  out_valid      <= 1'b1;
                  status         <= ST_REFUSED;
                  ticket         <= ticket_counter;
                  ticket_counter <= ticket_counter + TICKET_W'(1);
                end
              end
              MODE_REL: begin
                if (rel_ok) state <= S_REL1;
                else begin
                  out_valid <= 1'b1;
                  status    <= ST_FREE;
                  slot_out  <= slot_in;
                end
              end
              MODE_COL: begin
                if (col_empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                end else begin
                  cur   <= head_ptr;
                  count <= '0;
                  iters <= ({1'b0, max_list} < {1'b0, ring_size}) ? CNT_W'(max_list)
                                                                 : ring_size;
                  state <= S_COL;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_REQ: begin
          free_ptr  <= next_q;
          out_valid <= 1'b1;
          slot_out  <= free_ptr;
          state     <= S_IDLE;
        end
        S_REL1: begin
          if (client_ok_owner(owner_q) && hold_rd != '0) hold_cnt[hidx] <= hold_rd - HOLD_W'(1);
          slot_busy[rel_slot] <= 1'b0;
          if (rel_slot == head_ptr) begin
            head_ptr  <= next_q;
            out_valid <= 1'b1;
            slot_out  <= rel_slot;
            state     <= S_IDLE;
          end else begin
            state <= S_REL2;
          end
        end
        S_REL2: state <= S_REL3;
        S_REL3: state <= S_REL4;
        S_REL4: begin
          free_ptr  <= rel_slot;
          out_valid <= 1'b1;
          slot_out  <= rel_slot;
          state     <= S_IDLE;
        end
        S_COL: begin
          out_valid <= 1'b1;
          slot_out  <= cur;
          last      <= col_stop;
          cur       <= next_q;
          count     <= count_inc;
          if (col_stop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/slr_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module slr_ram #(
  parameter int W = 4,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/slr_checker.sv
// Port-level checks for packet_slot_ring_allocator, bound to the top level.
// Depends on slr_pkg.
module slr_checker import slr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                busy,
  input logic                out_valid,
  input logic [1:0]          status,
  input logic [SLOT_W-1:0]   slot_out,
  input logic [TICKET_W-1:0] ticket,
  input logic                last
);

  // reset starts the ring rebuild
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");
  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REFUSED |-> slot_out == '0 && last)
    else $error("refused beat carries a slot");
  a_ticket: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_REFUSED |-> ticket == '0)
    else $error("ticket on non-refused beat");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> last && slot_out == '0)
    else $error("empty collect beat malformed");

endmodule

bind packet_slot_ring_allocator slr_checker u_slr_checker (
  .clk, .rst, .busy, .out_valid, .status, .slot_out, .ticket, .last
);
